FILE: design/ptws_pkg.sv
`timescale 1ns / 1ps
package ptws_pkg;

   localparam int NODE_COUNT_DEF    = 1024;
   localparam int ALPHABET_SIZE_DEF = 26;

   localparam int KIND_W   = 2;
   localparam int LETTER_W = 5;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [LETTER_W-1:0] letter_type;

   localparam kind_type KIND_INSERT = 2'd0;
   localparam kind_type KIND_SEARCH = 2'd1;
   localparam kind_type KIND_PREFIX = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_LOOKUP,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic clear;
      logic req_ready;
      logic accept;
      logic walk;
      logic lookup;
      logic reply;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic item_last;
      logic rsp_free;
   } status_type;

endpackage

FILE: design/ptws_req_if.sv
`timescale 1ns / 1ps
interface ptws_req_if;
   import ptws_pkg::*;

   logic       valid;
   logic       ready;
   kind_type   kind;
   letter_type letter;
   logic       no_letter;
   logic       last;

   modport source (output valid, output kind, output letter, output no_letter, output last,
                   input ready);
   modport sink (input valid, input kind, input letter, input no_letter, input last,
                 output ready);
endinterface

FILE: design/ptws_rsp_if.sv
`timescale 1ns / 1ps
interface ptws_rsp_if;
   logic valid;
   logic ready;
   logic answer;
   logic pool_full;

   modport source (output valid, output answer, output pool_full, input ready);
   modport sink (input valid, input answer, input pool_full, output ready);
endinterface

FILE: design/ptws_ctrl.sv
`timescale 1ns / 1ps
module ptws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  ptws_pkg::status_type status,
   output ptws_pkg::cmd_type    cmd
);
   import ptws_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            state_in = status.item_last ? ST_LOOKUP : ST_IDLE;
         end
         ST_LOOKUP: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.accept    = req_valid;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_REPLY: begin
            cmd.reply = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: design/ptws_dp.sv
`timescale 1ns / 1ps
module ptws_dp #(
   parameter int NODE_COUNT    = ptws_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = ptws_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ptws_pkg::cmd_type    cmd,
   output ptws_pkg::status_type status,
   input  ptws_pkg::kind_type   req_kind,
   input  ptws_pkg::letter_type req_letter,
   input  logic                 req_no_letter,
   input  logic                 req_last,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 rsp_answer,
   output logic                 rsp_pool_full
);
   import ptws_pkg::*;

   localparam int NW    = $clog2(NODE_COUNT);
   localparam int UW    = $clog2(NODE_COUNT + 1);
   localparam int DEPTH = NODE_COUNT * ALPHABET_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] CLEAR_LAST = AW'(DEPTH - 1);

   logic [NW-1:0] child_mem [DEPTH];
   logic          mark_mem  [NODE_COUNT];

   kind_type      kind_ff;
   logic          no_letter_ff;
   logic          last_ff;
   logic          letter_ok_ff;
   logic [AW-1:0] slot_ff;
   logic [NW-1:0] child_rd_ff;
   logic          mark_rd_ff;

   logic [NW-1:0] current_ff, current_in;
   logic          missed_ff, missed_in;
   logic          overflow_ff, overflow_in;
   logic [UW-1:0] used_ff, used_in;
   logic [AW-1:0] clear_idx_ff;

   logic          rsp_valid_ff;
   logic          rsp_answer_ff;
   logic          rsp_pool_full_ff;

   logic          letter_ok;
   letter_type    letter_eff;
   logic [AW-1:0] slot_c;
   logic          child_we;
   logic          answer_c;

   assign letter_ok  = 32'(req_letter) < 32'(ALPHABET_SIZE);
   assign letter_eff = letter_ok ? req_letter : '0;
   assign slot_c     = AW'(current_ff) * AW'(ALPHABET_SIZE) + AW'(letter_eff);

   // one trie step: follow, allocate, or miss; a reply resets the walk
   always_comb begin
      current_in  = current_ff;
      missed_in   = missed_ff;
      overflow_in = overflow_ff;
      used_in     = used_ff;
      child_we    = 1'b0;
      if (cmd.walk && !no_letter_ff && !missed_ff) begin
         priority if (!letter_ok_ff) begin
            missed_in = 1'b1;
         end else if (child_rd_ff != '0) begin
            current_in = child_rd_ff;
         end else if (kind_ff != KIND_INSERT) begin
            missed_in = 1'b1;
         end else if (used_ff == UW'(NODE_COUNT)) begin
            missed_in   = 1'b1;
            overflow_in = 1'b1;
         end else begin
            child_we   = 1'b1;
            current_in = used_ff[NW-1:0];
            used_in    = used_ff + 1'b1;
         end
      end
      if (cmd.reply) begin
         current_in  = '0;
         missed_in   = 1'b0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff   <= '0;
         missed_ff    <= 1'b0;
         overflow_ff  <= 1'b0;
         used_ff      <= UW'(1);
         clear_idx_ff <= '0;
      end else begin
         current_ff  <= current_in;
         missed_ff   <= missed_in;
         overflow_ff <= overflow_in;
         used_ff     <= used_in;
         if (cmd.clear && clear_idx_ff != CLEAR_LAST) clear_idx_ff <= clear_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff      <= req_kind;
         no_letter_ff <= req_no_letter;
         last_ff      <= req_last;
         letter_ok_ff <= letter_ok;
         slot_ff      <= slot_c;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         child_mem[clear_idx_ff] <= '0;
      end else if (child_we) begin
         child_mem[slot_ff] <= used_ff[NW-1:0];
      end
      if (cmd.accept) child_rd_ff <= child_mem[slot_c];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         if (clear_idx_ff < AW'(NODE_COUNT)) mark_mem[clear_idx_ff[NW-1:0]] <= 1'b0;
      end else if (cmd.lookup && kind_ff == KIND_INSERT && !missed_ff) begin
         mark_mem[current_ff] <= 1'b1;
      end
      if (cmd.lookup) mark_rd_ff <= mark_mem[current_ff];
   end

   always_comb begin
      unique case (kind_ff)
         KIND_INSERT: answer_c = 1'b0;
         KIND_SEARCH: answer_c = !missed_ff && mark_rd_ff;
         default:     answer_c = !missed_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply) begin
         rsp_answer_ff    <= answer_c;
         rsp_pool_full_ff <= (kind_ff == KIND_INSERT) && overflow_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_answer    = rsp_answer_ff;
   assign rsp_pool_full = rsp_pool_full_ff;

   assign status.clear_done = clear_idx_ff == CLEAR_LAST;
   assign status.item_last  = last_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

FILE: design/prefix_tree_word_store.sv
`timescale 1ns / 1ps
// Trie dictionary of lower-case words, one letter per req transaction with an
// operation kind and a last mark; one rsp transaction per word, on its last item.
// Accepting a letter reads the child table at node*ALPHABET_SIZE+letter; the
// walk step then follows, allocates or misses. The last item adds the lookup
// state, which reads the end mark, and then the reply state; the reply waits
// while an earlier rsp transaction has not been taken. After reset a clearing
// pass zeroes the child table and end marks one entry per cycle, over all
// NODE_COUNT*ALPHABET_SIZE entries (26624 at the defaults), with req ready low.
module prefix_tree_word_store #(
   parameter int NODE_COUNT    = ptws_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = ptws_pkg::ALPHABET_SIZE_DEF
) (
   input logic        clock,
   input logic        reset,
   ptws_req_if.sink   req_ch,
   ptws_rsp_if.source rsp_ch
);
   import ptws_pkg::*;

   cmd_type    cmd;
   status_type status;

   ptws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   ptws_dp #(
      .NODE_COUNT    (NODE_COUNT),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_kind      (req_ch.kind),
      .req_letter    (req_ch.letter),
      .req_no_letter (req_ch.no_letter),
      .req_last      (req_ch.last),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_answer    (rsp_ch.answer),
      .rsp_pool_full (rsp_ch.pool_full)
   );

   assign req_ch.ready = cmd.req_ready;

   a_accept_walks: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.walk)
      else $error("accepted item not followed by a walk step");

   a_reply_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.reply |=> rsp_ch.valid)
      else $error("reply did not raise rsp valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !cmd.reply)
      else $error("reply overwrote a pending rsp transaction");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_ch.ready)
      else $error("req ready during clearing pass");

endmodule
